// File: src/jsr_pkg.sv
// shared types and constants of the jacobi stencil block
`timescale 1ns / 1ps

package jsr_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned RES_W     = 64;
  localparam int unsigned MIN_DIM   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [CFG_W-1:0] GRID_ROWS_RST = 11'd256;
  localparam logic [CFG_W-1:0] GRID_COLS_RST = 11'd256;

  // per-word control that travels from the scan counters into the datapath
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             has_left;
    logic             has_right;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } jsr_tag_t;

endpackage

// File: src/jsr_if.sv
// stream interfaces for grid samples in and relaxed points out
`timescale 1ns / 1ps

interface jsr_in_if #(
  parameter int unsigned VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface jsr_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [jsr_pkg::DATA_W-1:0]   new_value;
  logic        [jsr_pkg::POS_W-1:0]    out_row;
  logic        [jsr_pkg::POS_W-1:0]    out_col;
  logic        [jsr_pkg::RES_W-1:0]    residual;
  logic                                last;

  modport source (output valid, output new_value, output out_row, output out_col,
                  output residual, output last, input ready);
  modport sink   (input valid, input new_value, input out_row, input out_col,
                  input residual, input last, output ready);
endinterface

// File: src/jsr_ram.sv
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module jsr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: src/jsr_scan.sv
// grid size registers, raster counters and line buffer addressing
`timescale 1ns / 1ps

module jsr_scan #(
  parameter int unsigned MAX_DIM = 1024,
  localparam int unsigned AW = $clog2(MAX_DIM)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [jsr_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            accept_i,
  output logic [AW-1:0]                   raddr_a_o,
  output logic [AW-1:0]                   raddr_b_o,
  output jsr_pkg::jsr_tag_t               tag_o
);

  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned EW = DW + 1;
  localparam int unsigned CW = (DW > jsr_pkg::CFG_W) ? DW : jsr_pkg::CFG_W;
  localparam int unsigned PW = (EW > jsr_pkg::POS_W) ? EW : jsr_pkg::POS_W;
  localparam logic [CW-1:0] DIM_LO = CW'(jsr_pkg::MIN_DIM);
  localparam logic [CW-1:0] DIM_HI = CW'(MAX_DIM);

  logic [jsr_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [CW-1:0] rows_ext, cols_ext;
  logic [DW-1:0] rows_w, cols_w;
  logic [EW-1:0] rows_e, cols_e;

  logic [AW-1:0] col_q, col_d, row_q, row_d;
  logic [EW-1:0] col_e, row_e, row_bump, row_cur, col_cur, col_p1, col_p2, row_p1;
  logic          col_wrap;
  logic [PW-1:0] row_up, col_up;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= jsr_pkg::GRID_ROWS_RST;
      cols_cfg_q <= jsr_pkg::GRID_COLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jsr_pkg::REG_GRID_ROWS: rows_cfg_q <= cfg_wdata_i;
        jsr_pkg::REG_GRID_COLS: cols_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // out-of-range sizes are pinned to the legal range
  assign rows_ext = CW'(rows_cfg_q);
  assign cols_ext = CW'(cols_cfg_q);
  assign rows_w = (rows_ext < DIM_LO) ? DIM_LO[DW-1:0] :
                  (rows_ext > DIM_HI) ? DIM_HI[DW-1:0] : rows_ext[DW-1:0];
  assign cols_w = (cols_ext < DIM_LO) ? DIM_LO[DW-1:0] :
                  (cols_ext > DIM_HI) ? DIM_HI[DW-1:0] : cols_ext[DW-1:0];
  assign rows_e = EW'(rows_w);
  assign cols_e = EW'(cols_w);

  // a size change can leave the counters past the end: wrap them first
  always_comb begin
    col_e    = EW'(col_q);
    row_e    = EW'(row_q);
    col_wrap = (col_e >= cols_e);
    row_bump = col_wrap ? row_e + EW'(1) : row_e;
    row_cur  = (row_bump >= rows_e) ? '0 : row_bump;
    col_cur  = col_wrap ? '0 : col_e;
    col_p1   = col_cur + EW'(1);
    col_p2   = col_cur + EW'(2);
    row_p1   = row_cur + EW'(1);
    row_up   = PW'(row_cur) - PW'(1);
    col_up   = PW'(col_cur);

    tag_o.emit      = (row_cur >= EW'(2)) && (col_cur != '0) && (col_p2 <= cols_e);
    tag_o.last      = (row_p1 == rows_e) && (col_p2 == cols_e);
    tag_o.has_left  = (col_cur != '0);
    tag_o.has_right = (col_p1 < cols_e);
    tag_o.row       = row_up[jsr_pkg::POS_W-1:0];
    tag_o.col       = col_up[jsr_pkg::POS_W-1:0];

    raddr_a_o = col_cur[AW-1:0];
    raddr_b_o = col_p1[AW-1:0];

    if (col_p1 >= cols_e) begin
      col_d = '0;
      row_d = (row_p1 >= rows_e) ? '0 : row_p1[AW-1:0];
    end else begin
      col_d = col_p1[AW-1:0];
      row_d = row_cur[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: src/jsr_relax.sv
// stencil datapath: neighbour sum, change, square, saturating residual
`timescale 1ns / 1ps

module jsr_relax #(
  parameter int unsigned AW = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  jsr_pkg::jsr_tag_t                  tag_i,
  input  logic [AW-1:0]                      addr_i,
  input  logic signed [jsr_pkg::DATA_W-1:0]  sample_i,
  output logic                               ready_o,
  input  logic [2*jsr_pkg::DATA_W-1:0]       rdata_a_i,
  input  logic [2*jsr_pkg::DATA_W-1:0]       rdata_b_i,
  output logic                               ram_we_o,
  output logic [AW-1:0]                      ram_waddr_o,
  output logic [2*jsr_pkg::DATA_W-1:0]       ram_wdata_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [jsr_pkg::DATA_W-1:0]  new_value_o,
  output logic [jsr_pkg::POS_W-1:0]          out_row_o,
  output logic [jsr_pkg::POS_W-1:0]          out_col_o,
  output logic [jsr_pkg::RES_W-1:0]          residual_o,
  output logic                               last_o
);

  localparam int unsigned DW = jsr_pkg::DATA_W;
  localparam int unsigned RW = jsr_pkg::RES_W;

  // stage 1: line buffer data arrives
  logic                 p1_v_q;
  jsr_pkg::jsr_tag_t    p1_tag_q;
  logic [AW-1:0]        p1_addr_q;
  logic signed [DW-1:0] p1_bottom_q;
  logic signed [DW-1:0] win_q;
  logic signed [DW-1:0] centre, top, left, right;
  logic signed [DW+1:0] sum;
  logic                 p1_retire;

  // stage 2: sum
  logic                 p2_v_q;
  jsr_pkg::jsr_tag_t    p2_tag_q;
  logic signed [DW+1:0] p2_sum_q;
  logic signed [DW-1:0] p2_centre_q;
  logic signed [DW-1:0] nv;
  logic signed [DW:0]   diff;
  logic        [DW:0]   mag;

  // stage 3: new value and magnitude of change
  logic                 p3_v_q;
  jsr_pkg::jsr_tag_t    p3_tag_q;
  logic signed [DW-1:0] p3_nv_q;
  logic        [DW-1:0] p3_mag_q;

  // stage 4: squared change
  logic                 p4_v_q;
  jsr_pkg::jsr_tag_t    p4_tag_q;
  logic signed [DW-1:0] p4_nv_q;
  logic        [RW-1:0] p4_sq_q;

  // output word
  logic                 out_v_q;
  jsr_pkg::jsr_tag_t    out_tag_q;
  logic signed [DW-1:0] out_nv_q;
  logic        [RW-1:0] out_res_q;
  logic        [RW-1:0] acc_q;
  logic        [RW:0]   acc_sum;
  logic        [RW-1:0] acc_sat;

  logic out_free, p4_free, p3_free, p2_free;

  assign out_free = !out_v_q || out_ready_i;
  assign p4_free  = !p4_v_q || out_free;
  assign p3_free  = !p3_v_q || p4_free;
  assign p2_free  = !p2_v_q || p3_free;

  // border words never enter stage 2 and leave stage 1 at once
  assign p1_retire = p1_v_q && (!p1_tag_q.emit || p2_free);
  assign ready_o   = !p1_v_q || p1_retire;

  always_comb begin
    centre = rdata_a_i[DW-1:0];
    top    = rdata_a_i[2*DW-1:DW];
    right  = p1_tag_q.has_right ? rdata_b_i[DW-1:0] : '0;
    left   = p1_tag_q.has_left ? win_q : '0;
    sum    = (DW+2)'(left) + (DW+2)'(right) + (DW+2)'(top) + (DW+2)'(p1_bottom_q);
  end

  // the row just read moves to the older half, the new sample to the newer half
  assign ram_we_o    = p1_retire;
  assign ram_waddr_o = p1_addr_q;
  assign ram_wdata_o = {centre, p1_bottom_q};

  always_comb begin
    nv   = p2_sum_q[DW+1:2];
    diff = (DW+1)'(nv) - (DW+1)'(p2_centre_q);
    mag  = diff[DW] ? -diff : diff;
  end

  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, p4_sq_q};
    acc_sat = acc_sum[RW] ? '1 : acc_sum[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      win_q   <= '0;
      acc_q   <= '0;
    end else begin
      p1_v_q  <= accept_i || (p1_v_q && !p1_retire);
      p2_v_q  <= (p1_retire && p1_tag_q.emit) || (p2_v_q && !p3_free);
      p3_v_q  <= (p2_v_q && p3_free) || (p3_v_q && !p4_free);
      p4_v_q  <= (p3_v_q && p4_free) || (p4_v_q && !out_free);
      out_v_q <= (p4_v_q && out_free) || (out_v_q && !out_ready_i);
      if (p1_retire) begin
        win_q <= centre;
      end
      if (p4_v_q && out_free) begin
        acc_q <= p4_tag_q.last ? '0 : acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      p1_tag_q    <= tag_i;
      p1_addr_q   <= addr_i;
      p1_bottom_q <= sample_i;
    end
    if (p1_retire && p1_tag_q.emit) begin
      p2_tag_q    <= p1_tag_q;
      p2_sum_q    <= sum;
      p2_centre_q <= centre;
    end
    if (p2_v_q && p3_free) begin
      p3_tag_q <= p2_tag_q;
      p3_nv_q  <= nv;
      p3_mag_q <= mag[DW-1:0];
    end
    if (p3_v_q && p4_free) begin
      p4_tag_q <= p3_tag_q;
      p4_nv_q  <= p3_nv_q;
      p4_sq_q  <= RW'(p3_mag_q) * RW'(p3_mag_q);
    end
    if (p4_v_q && out_free) begin
      out_tag_q <= p4_tag_q;
      out_nv_q  <= p4_nv_q;
      out_res_q <= acc_sat;
    end
  end

  assign out_valid_o = out_v_q;
  assign new_value_o = out_nv_q;
  assign out_row_o   = out_tag_q.row;
  assign out_col_o   = out_tag_q.col;
  assign residual_o  = out_res_q;
  assign last_o      = out_tag_q.last;

endmodule

// File: src/jacobi_stencil_relaxation.sv
// top level of the five-point jacobi relaxation block
`timescale 1ns / 1ps

// Grid samples enter on in_if one word per cycle in raster order, borders
// included; grid_rows and grid_cols are set through the cfg write port while
// the block is idle (register 0 rows, register 1 cols, range 3 to MAX_DIM).
// For every interior point a word leaves on out_if after the sample below it
// is taken: the quarter of the four neighbour sum, its row and column, the
// saturating Q64.0 residual so far, and last on the frame's final point,
// after which the residual starts again from zero.
// Throughput is one sample per cycle unless the receiver stalls: both line
// buffers share one ram with one write and two read ports, and a single
// 32x32 multiplier squares the change. The sample below reaches the output
// word through the ram read and the stage 2, 3, 4 and output registers.
// Reset clears the counters, the left-neighbour register and the residual
// and sets both sizes to 256; the ram is not cleared, and the two border rows
// at the top of a frame emit nothing. When the receiver stalls, the datapath
// holds and samples are still taken until an interior sample waits in stage 1
// behind a full pipeline, since border samples pass stage 1 without waiting.
module jacobi_stencil_relaxation #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [jsr_pkg::CFG_W-1:0]     cfg_wdata_i,
  jsr_in_if.sink                        in_if,
  jsr_out_if.source                     out_if
);

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned DW = jsr_pkg::DATA_W;

  logic                 accept;
  logic                 ready;
  logic [AW-1:0]        raddr_a, raddr_b, waddr;
  logic [2*DW-1:0]      rdata_a, rdata_b, wdata;
  logic                 we;
  jsr_pkg::jsr_tag_t    tag;
  logic signed [VALUE_BITS-1:0] sample_raw;
  logic signed [DW-1:0] sample_ext;

  assign in_if.ready = ready;
  assign accept      = in_if.valid && ready;
  assign sample_raw  = in_if.sample_value;
  assign sample_ext  = DW'(sample_raw);

  jsr_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .tag_o       (tag)
  );

  jsr_ram #(
    .WIDTH (2 * DW),
    .DEPTH (MAX_DIM)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (accept),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (accept),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  jsr_relax #(
    .AW (AW)
  ) u_relax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .tag_i       (tag),
    .addr_i      (raddr_a),
    .sample_i    (sample_ext),
    .ready_o     (ready),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .ram_we_o    (we),
    .ram_waddr_o (waddr),
    .ram_wdata_o (wdata),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .new_value_o (out_if.new_value),
    .out_row_o   (out_if.out_row),
    .out_col_o   (out_if.out_col),
    .residual_o  (out_if.residual),
    .last_o      (out_if.last)
  );

endmodule

// File: src/jsr_checker.sv
// port-level assertions for the jacobi stencil block and their bind
`timescale 1ns / 1ps

module jsr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [jsr_pkg::DATA_W-1:0]    new_value_i,
  input logic [jsr_pkg::POS_W-1:0]     out_row_i,
  input logic [jsr_pkg::POS_W-1:0]     out_col_i,
  input logic [jsr_pkg::RES_W-1:0]     residual_i,
  input logic                          last_i
);

  // the input side only backs up behind a stalled output word
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled while the output side was free");

  // interior points never sit on row or column zero
  a_interior : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_row_i != '0 && out_col_i != '0))
    else $error("output word names a border point");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(new_value_i) && $stable(residual_i) && $stable(last_i) &&
       $stable(out_row_i) && $stable(out_col_i)))
    else $error("output word changed while stalled");

endmodule

bind jacobi_stencil_relaxation jsr_checker u_jsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .new_value_i (out_if.new_value),
  .out_row_i   (out_if.out_row),
  .out_col_i   (out_if.out_col),
  .residual_i  (out_if.residual),
  .last_i      (out_if.last)
);
